[hdl/stp_pkg.sv]
// Shared types, widths and codes for the stepper trapezoid planner.
`default_nettype none
package stp_pkg;

	localparam int POSITION_BITS = 24;
	localparam int STEP_BITS     = 16;

	localparam int TARGET_W = 24;
	localparam int RATE_W   = 16;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 2;

	// width for position compare and distance
	localparam int CMP_W = ((POSITION_BITS > TARGET_W) ? POSITION_BITS : TARGET_W) + 1;

	// largest step count a move can report
	localparam logic [RATE_W-1:0] STEP_SAT = (STEP_BITS >= RATE_W) ?
		{RATE_W{1'b1}} : RATE_W'((1 << STEP_BITS) - 1);

	localparam int DVD_W = 2 * RATE_W;
	localparam int DVS_W = RATE_W + 1;
	localparam int DCNT_W = $clog2(DVD_W);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_JERK  = 2'd0,
		REG_ACCEL = 2'd1,
		REG_MIN   = 2'd2,
		REG_DROP  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [RATE_W-1:0] jerk_rate;
		logic [RATE_W-1:0] accel;
		logic [RATE_W-1:0] min_rate;
		logic [RATE_W-1:0] drop_length;
	} cfg_t;

	typedef struct packed {
		logic             busy;
		logic [DVD_W-1:0] quot;
		logic             rem_nz;
	} div_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIST,
		ST_PREP,
		ST_SQN,
		ST_SQI,
		ST_DIVS,
		ST_DIVW,
		ST_FIN
	} state_t;

endpackage
`default_nettype wire

[hdl/stp_cfg.sv]
// Configuration register file of the stepper trapezoid planner.
`default_nettype none
module stp_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [stp_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [stp_pkg::CFG_W-1:0]     cfg_wdata,
	output stp_pkg::cfg_t                      cfg
);
	import stp_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.jerk_rate   <= '0;
			cfg_q.accel       <= RATE_W'(1);
			cfg_q.min_rate    <= RATE_W'(120);
			cfg_q.drop_length <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_JERK:  cfg_q.jerk_rate   <= cfg_wdata;
				REG_ACCEL: cfg_q.accel       <= cfg_wdata;
				REG_MIN:   cfg_q.min_rate    <= cfg_wdata;
				REG_DROP:  cfg_q.drop_length <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

[hdl/stp_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module stp_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [stp_pkg::DVD_W-1:0] dividend,
	input  wire logic [stp_pkg::DVS_W-1:0] divisor,
	output stp_pkg::div_stat_t             stat
);
	import stp_pkg::*;

	logic              busy_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [DVS_W:0]    rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DVS_W:0]    trial;
	logic              fits;

	assign trial = {rem_q[DVS_W-1:0], quo_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DCNT_W'(DVD_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, dvs_q}) : trial;
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign stat.busy   = busy_q;
	assign stat.quot   = quo_q;
	assign stat.rem_nz = |rem_q;

endmodule
`default_nettype wire

[hdl/stepper_trapezoid_planner.sv]
// Top level of the stepper trapezoid planner: sequencer, squarer and result register.
// A move request runs through distance, rate clamping, two squarings on one 16x16
// multiplier and the divider start. Then the bit-serial divider produces the
// quotient bits one by one and is seen to finish. It divides the difference of the
// squared cruise and start rates by twice the acceleration, giving the ramp length.
// A last step loads the result. in_stall stays high while a move is being planned.
// Moves of drop_length steps or fewer go back to idle with no result. The result
// sits in an output register, so a new move is accepted while it waits; a move
// can only finish once that register is free.
`default_nettype none
module stepper_trapezoid_planner (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [stp_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  wire logic [stp_pkg::CFG_W-1:0]           cfg_wdata,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [stp_pkg::TARGET_W-1:0] target_pos,
	input  wire logic [stp_pkg::RATE_W-1:0]          feed,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [stp_pkg::RATE_W-1:0]               move_steps,
	output logic                                     dir_up,
	output logic [stp_pkg::RATE_W-1:0]               cruise_rate,
	output logic [stp_pkg::RATE_W-1:0]               start_rate,
	output logic [stp_pkg::RATE_W-1:0]               end_rate,
	output logic [stp_pkg::RATE_W-1:0]               accel_until,
	output logic [stp_pkg::RATE_W-1:0]               decel_after
);
	import stp_pkg::*;

	cfg_t      cfg;
	div_stat_t dstat;

	state_t state_q, state_d;
	logic   in_fire, div_start, fin_fire;

	logic signed [TARGET_W-1:0]      target_q;
	logic [RATE_W-1:0]               feed_q;
	logic signed [POSITION_BITS-1:0] pos_q;
	logic [CMP_W-1:0]                dist_q;
	logic                            dir_q;
	logic [RATE_W-1:0]               steps_q;
	logic [RATE_W-1:0]               start_q;
	logic [DVD_W-1:0]                n2_q, i2_q;

	logic signed [CMP_W-1:0] tgt_ext, pos_ext, diff;
	logic [RATE_W-1:0]       rate_lo, rate_cl, mul_op;
	logic [DVD_W-1:0]        prod;
	logic [RATE_W-1:0]       accel_nz;
	logic [DVS_W-1:0]        accel2;
	logic [DVD_W:0]          ramp_sum;
	logic                    plateau;
	logic [RATE_W-1:0]       half_up;

	stp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	assign accel_nz = (cfg.accel == '0) ? RATE_W'(1) : cfg.accel;
	assign accel2   = {accel_nz, 1'b0};

	stp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (n2_q - i2_q),
		.divisor  (accel2),
		.stat     (dstat)
	);

	assign in_fire  = in_valid && !in_stall;
	assign tgt_ext  = CMP_W'(target_q);
	assign pos_ext  = CMP_W'(pos_q);
	assign diff     = tgt_ext - pos_ext;
	assign rate_lo  = (cfg.jerk_rate < cfg.min_rate) ? cfg.min_rate : cfg.jerk_rate;
	assign rate_cl  = (rate_lo > feed_q) ? feed_q : rate_lo;
	assign mul_op   = (state_q == ST_SQN) ? feed_q : start_q;
	assign prod     = mul_op * mul_op;
	assign ramp_sum = {dstat.quot, 1'b0} + (DVD_W + 1)'(dstat.rem_nz);
	assign plateau  = ramp_sum < (DVD_W + 1)'(steps_q);
	assign half_up  = (steps_q >> 1) + RATE_W'(steps_q[0]);

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		div_start = 1'b0;
		fin_fire  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid)
					state_d = ST_DIST;
			end
			ST_DIST: state_d = ST_PREP;
			ST_PREP: state_d = (dist_q > CMP_W'(cfg.drop_length)) ? ST_SQN : ST_IDLE;
			ST_SQN:  state_d = ST_SQI;
			ST_SQI:  state_d = ST_DIVS;
			ST_DIVS: begin
				div_start = 1'b1;
				state_d   = ST_DIVW;
			end
			ST_DIVW: begin
				if (!dstat.busy)
					state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!out_valid || !out_stall) begin
					fin_fire = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (fin_fire) begin
				pos_q     <= POSITION_BITS'(tgt_ext);
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			target_q <= target_pos;
			feed_q   <= feed;
		end
		if (state_q == ST_DIST) begin
			dir_q  <= !diff[CMP_W-1];
			dist_q <= diff[CMP_W-1] ? CMP_W'(-diff) : CMP_W'(diff);
		end
		if (state_q == ST_PREP) begin
			steps_q <= (dist_q > CMP_W'(STEP_SAT)) ? STEP_SAT : dist_q[RATE_W-1:0];
			start_q <= rate_cl;
		end
		if (state_q == ST_SQN)
			n2_q <= prod;
		if (state_q == ST_SQI)
			i2_q <= prod;
		if (fin_fire) begin
			move_steps  <= steps_q;
			dir_up      <= dir_q;
			cruise_rate <= feed_q;
			start_rate  <= start_q;
			end_rate    <= start_q;
			if (plateau) begin
				accel_until <= dstat.quot[RATE_W-1:0] + RATE_W'(dstat.rem_nz);
				decel_after <= steps_q - dstat.quot[RATE_W-1:0];
			end else begin
				accel_until <= half_up;
				decel_after <= half_up;
			end
		end
	end

endmodule
`default_nettype wire
